// File: rtl/signed_byte_alu_macros.svh
// ----------------------------------------------------------------------------
// signed_byte_alu assertion macros
// Shared property wrappers for the signed byte ALU checks.
// ----------------------------------------------------------------------------
`ifndef SIGNED_BYTE_ALU_MACROS_SVH
`define SIGNED_BYTE_ALU_MACROS_SVH

// same-cycle implication, disabled in reset
`define SBA_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("signed_byte_alu: same-cycle check failed");

// next-cycle implication, disabled in reset
`define SBA_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("signed_byte_alu: next-cycle check failed");

`endif

// File: rtl/sba_pkg.sv
// ----------------------------------------------------------------------------
// sba_pkg
// Operation codes, field widths and the unit command type of the signed ALU.
// ----------------------------------------------------------------------------
package sba_pkg;

   // beat field widths
   localparam int FUNC_W    = 3;
   localparam int OPERAND_W = 8;
   localparam int RESULT_W  = 8;

   // operation codes
   localparam logic [FUNC_W-1:0] FUNC_ADD = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_SUB = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_MUL = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_DIV = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_REM = 3'd4;

   // command from the sequencer to an arithmetic unit
   typedef struct packed {
      logic              start;
      logic [FUNC_W-1:0] func;
   } sba_cmd_type;

endpackage

// File: rtl/sba_addsub.sv
// ----------------------------------------------------------------------------
// sba_addsub
// Bit-serial adder/subtractor: one bit per cycle, LSB first, through
// shift registers and a single carry flop.
// ----------------------------------------------------------------------------
module sba_addsub #(
   parameter int DATA_WIDTH = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  sba_pkg::sba_cmd_type   cmd,
   input  logic [DATA_WIDTH-1:0]  opa,
   input  logic [DATA_WIDTH-1:0]  opb,
   output logic [DATA_WIDTH-1:0]  sum,
   output logic                   done
);

   localparam int CNT_W = $clog2(DATA_WIDTH);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_WIDTH - 1);

   logic [DATA_WIDTH-1:0] a_sr_ff;
   logic [DATA_WIDTH-1:0] b_sr_ff;
   logic [DATA_WIDTH-1:0] sum_sr_ff;
   logic                  carry_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic                  run_ff;
   logic                  done_ff;
   logic                  is_sub;
   logic                  bit_sum_in;
   logic                  carry_in;

   assign is_sub = (cmd.func == sba_pkg::FUNC_SUB);

   // one full-adder cell
   assign bit_sum_in = a_sr_ff[0] ^ b_sr_ff[0] ^ carry_ff;
   assign carry_in   = (a_sr_ff[0] & b_sr_ff[0]) | (a_sr_ff[0] & carry_ff) |
                       (b_sr_ff[0] & carry_ff);

   // control flops
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (cmd.start) begin
         run_ff  <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (run_ff) begin
         cnt_ff <= cnt_ff + 1'b1;
         if (cnt_ff == CNT_LAST) begin
            run_ff  <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   // operand and sum shift registers; subtract is a + ~b + 1
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         a_sr_ff  <= opa;
         b_sr_ff  <= is_sub ? ~opb : opb;
         carry_ff <= is_sub;
      end else if (run_ff) begin
         a_sr_ff   <= a_sr_ff >> 1;
         b_sr_ff   <= b_sr_ff >> 1;
         carry_ff  <= carry_in;
         sum_sr_ff <= {bit_sum_in, sum_sr_ff[DATA_WIDTH-1:1]};
      end
   end

   assign sum  = sum_sr_ff;
   assign done = done_ff;

endmodule

// File: rtl/sba_muldiv.sv
// ----------------------------------------------------------------------------
// sba_muldiv
// Iterative multiply (shift-add) and divide/remainder (restoring, on
// magnitudes) with one bit per cycle and a final sign fix-up state.
// ----------------------------------------------------------------------------
module sba_muldiv #(
   parameter int DATA_WIDTH = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  sba_pkg::sba_cmd_type   cmd,
   input  logic [DATA_WIDTH-1:0]  opa,
   input  logic [DATA_WIDTH-1:0]  opb,
   output logic [DATA_WIDTH-1:0]  res,
   output logic                   div_zero,
   output logic                   done
);

   localparam int CNT_W = $clog2(DATA_WIDTH);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_WIDTH - 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_ITER,
      S_FIX,
      S_DONE
   } state_type;

   state_type                     state_ff;
   logic [CNT_W-1:0]              cnt_ff;
   logic [sba_pkg::FUNC_W-1:0]    func_ff;
   logic [DATA_WIDTH-1:0]         acc_ff;
   logic [DATA_WIDTH-1:0]         sr_ff;
   logic [DATA_WIDTH-1:0]         opd_ff;
   logic                          neg_a_ff;
   logic                          neg_q_ff;
   logic                          zero_b_ff;
   logic [DATA_WIDTH-1:0]         res_ff;
   logic                          div_zero_ff;

   logic [DATA_WIDTH-1:0]         a_mag;
   logic [DATA_WIDTH-1:0]         b_mag;
   logic [DATA_WIDTH:0]           shifted;
   logic [DATA_WIDTH+1:0]         diff;
   logic                          borrow;
   logic [DATA_WIDTH-1:0]         acc_in;
   logic [DATA_WIDTH-1:0]         sr_in;
   logic [DATA_WIDTH-1:0]         opd_in;
   logic [DATA_WIDTH-1:0]         res_in;
   logic                          is_mul;

   assign is_mul = (func_ff == sba_pkg::FUNC_MUL);

   // operand magnitudes for the divider
   assign a_mag = opa[DATA_WIDTH-1] ? (~opa + 1'b1) : opa;
   assign b_mag = opb[DATA_WIDTH-1] ? (~opb + 1'b1) : opb;

   // restoring divide step: shift in the next dividend bit, try subtract
   assign shifted = {acc_ff, sr_ff[DATA_WIDTH-1]};
   assign diff    = {1'b0, shifted} - {2'b00, opd_ff};
   assign borrow  = diff[DATA_WIDTH+1];

   // next values of the iteration registers
   always_comb begin
      if (is_mul) begin
         acc_in = sr_ff[0] ? (acc_ff + opd_ff) : acc_ff;
         sr_in  = sr_ff >> 1;
         opd_in = opd_ff << 1;
      end else begin
         acc_in = borrow ? shifted[DATA_WIDTH-1:0] : diff[DATA_WIDTH-1:0];
         sr_in  = {sr_ff[DATA_WIDTH-2:0], ~borrow};
         opd_in = opd_ff;
      end
   end

   // product as is, sign fix-up of quotient or remainder, 0 on a zero divisor
   always_comb begin
      case (func_ff)
         sba_pkg::FUNC_MUL: res_in = acc_ff;
         sba_pkg::FUNC_DIV: res_in = zero_b_ff ? '0 : (neg_q_ff ? (~sr_ff + 1'b1) : sr_ff);
         sba_pkg::FUNC_REM: res_in = zero_b_ff ? '0 : (neg_a_ff ? (~acc_ff + 1'b1) : acc_ff);
         default:           res_in = '0;
      endcase
   end

   // sequencer and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else if (cmd.start) begin
         state_ff  <= S_ITER;
         cnt_ff    <= '0;
         func_ff   <= cmd.func;
         acc_ff    <= '0;
         neg_a_ff  <= opa[DATA_WIDTH-1];
         neg_q_ff  <= opa[DATA_WIDTH-1] ^ opb[DATA_WIDTH-1];
         zero_b_ff <= (opb == '0);
         if (cmd.func == sba_pkg::FUNC_MUL) begin
            sr_ff  <= opa;
            opd_ff <= opb;
         end else begin
            sr_ff  <= a_mag;
            opd_ff <= b_mag;
         end
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               state_ff <= S_IDLE;
            end
            S_ITER: begin
               acc_ff <= acc_in;
               sr_ff  <= sr_in;
               opd_ff <= opd_in;
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == CNT_LAST) begin
                  state_ff <= S_FIX;
               end
            end
            S_FIX: begin
               res_ff      <= res_in;
               div_zero_ff <= zero_b_ff && !is_mul;
               state_ff    <= S_DONE;
            end
            S_DONE: begin
               state_ff <= S_DONE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign res      = res_ff;
   assign div_zero = div_zero_ff;
   assign done     = (state_ff == S_DONE);

endmodule

// File: rtl/signed_byte_alu.sv
// ----------------------------------------------------------------------------
// signed_byte_alu
// Signed two's complement ALU: add, subtract, multiply, divide, remainder.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one beat per operation; tuser carries the operation code,
//   tdata the two operands. rsp channel: one beat per request with the
//   wrapped result in tdata and the divide-by-zero flag in tuser.
//   Divide truncates toward zero; remainder has the dividend's sign; a zero
//   divisor gives result 0 with the flag set; unused codes give 0.
//   Operations run bit-serially over the DATA_WIDTH-bit datapath, one bit
//   per cycle. Add and subtract run in the serial adder; multiply, divide
//   and remainder run in the shift-add / restoring divide unit and end
//   with a sign fix-up step; unused codes use no unit. One request is in
//   flight at a time: a new request is taken only once the previous
//   result has moved into the output register.
//   The result sits in an output register, so the next request is taken
//   while it waits. If rsp_tready stays low, the finished next result waits
//   in its unit and req_tready stays low until the output register frees.
//   Reset (synchronous, active high) drops both valid/ready handshakes to
//   idle and discards any operation in progress.
// ----------------------------------------------------------------------------
`include "signed_byte_alu_macros.svh"

module signed_byte_alu #(
   parameter int DATA_WIDTH = 8
) (
   input  logic        clock,
   input  logic        reset,
   // request beat
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] operand_a, [15:8] operand_b
   input  logic [2:0]  req_tuser,   // [2:0] func
   // response beat
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] result
   output logic [0:0]  rsp_tuser    // [0] divide_by_zero
);

   // operands are taken in the low bits of the byte fields
   localparam int MIN_W = (DATA_WIDTH < sba_pkg::OPERAND_W) ? DATA_WIDTH :
                          sba_pkg::OPERAND_W;

   typedef enum logic {
      S_IDLE,
      S_BUSY
   } state_type;

   state_type                   state_ff;
   logic [sba_pkg::FUNC_W-1:0]  func_ff;
   logic                        rsp_valid_ff;
   logic [sba_pkg::RESULT_W-1:0] rsp_result_ff;
   logic                        rsp_dz_ff;

   logic                        req_accept;
   logic                        out_free;
   logic                        rsp_load;
   logic [sba_pkg::FUNC_W-1:0]  req_func;
   logic [DATA_WIDTH-1:0]       opa;
   logic [DATA_WIDTH-1:0]       opb;
   sba_pkg::sba_cmd_type        as_cmd;
   sba_pkg::sba_cmd_type        md_cmd;
   logic [DATA_WIDTH-1:0]       as_sum;
   logic                        as_done;
   logic [DATA_WIDTH-1:0]       md_res;
   logic                        md_dz;
   logic                        md_done;
   logic                        unit_done;
   logic [DATA_WIDTH-1:0]       unit_res;
   logic                        unit_dz;

   // request unpack
   assign req_func   = req_tuser;
   assign opa        = DATA_WIDTH'(req_tdata[MIN_W-1:0]);
   assign opb        = DATA_WIDTH'(req_tdata[sba_pkg::OPERAND_W +: MIN_W]);
   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_load   = (state_ff == S_BUSY) && unit_done && out_free;

   // unit dispatch
   always_comb begin
      as_cmd.func  = req_func;
      md_cmd.func  = req_func;
      as_cmd.start = 1'b0;
      md_cmd.start = 1'b0;
      case (req_func) inside
         sba_pkg::FUNC_ADD, sba_pkg::FUNC_SUB: as_cmd.start = req_accept;
         sba_pkg::FUNC_MUL, sba_pkg::FUNC_DIV,
         sba_pkg::FUNC_REM:                    md_cmd.start = req_accept;
         default:                              ;
      endcase
   end

   sba_addsub #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_addsub (
      .clock (clock),
      .reset (reset),
      .cmd   (as_cmd),
      .opa   (opa),
      .opb   (opb),
      .sum   (as_sum),
      .done  (as_done)
   );

   sba_muldiv #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_muldiv (
      .clock    (clock),
      .reset    (reset),
      .cmd      (md_cmd),
      .opa      (opa),
      .opb      (opb),
      .res      (md_res),
      .div_zero (md_dz),
      .done     (md_done)
   );

   // result select for the operation in flight
   always_comb begin
      case (func_ff) inside
         sba_pkg::FUNC_ADD, sba_pkg::FUNC_SUB: begin
            unit_done = as_done;
            unit_res  = as_sum;
            unit_dz   = 1'b0;
         end
         sba_pkg::FUNC_MUL, sba_pkg::FUNC_DIV, sba_pkg::FUNC_REM: begin
            unit_done = md_done;
            unit_res  = md_res;
            unit_dz   = md_dz;
         end
         default: begin
            unit_done = 1'b1;
            unit_res  = '0;
            unit_dz   = 1'b0;
         end
      endcase
   end

   // sequencer and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // load a finished result, else drop a taken beat
         if (rsp_load) begin
            rsp_result_ff <= sba_pkg::RESULT_W'(unit_res[MIN_W-1:0]);
            rsp_dz_ff     <= unit_dz;
            rsp_valid_ff  <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff  <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_accept) begin
                  func_ff  <= req_func;
                  state_ff <= S_BUSY;
               end
            end
            S_BUSY: begin
               if (rsp_load) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_result_ff;
   assign rsp_tuser[0] = rsp_dz_ff;

   // checks
   `SBA_ASSERT_NEXT(a_accept_blocks, clock, reset, req_tvalid && req_tready, !req_tready)
   `SBA_ASSERT_NEXT(a_load_frees, clock, reset, rsp_load, rsp_tvalid && req_tready)
   `SBA_ASSERT_IMPL(a_dz_zero_result, clock, reset, rsp_tvalid && rsp_tuser[0], rsp_tdata == '0)

endmodule

// File: sim/signed_byte_alu_checker.sv
// ----------------------------------------------------------------------------
// signed_byte_alu_checker
// Watches the req and rsp channels of the signed byte ALU, works out the
// expected response for every accepted req beat and compares each rsp beat
// against the oldest outstanding one.
// ----------------------------------------------------------------------------
module signed_byte_alu_checker (
   input  logic                              clock,
   input  logic                              reset,
   // request beat
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   input  logic [2*sba_pkg::OPERAND_W-1:0]   req_tdata,   // [7:0] operand_a, [15:8] operand_b
   input  logic [sba_pkg::FUNC_W-1:0]        req_tuser,   // [2:0] func
   // response beat
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic [sba_pkg::RESULT_W-1:0]      rsp_tdata,   // [7:0] result
   input  logic [0:0]                        rsp_tuser,   // [0] divide_by_zero
   // status for the testbench top
   output int                                error_count,
   output int                                outstanding,
   output int                                checked_count
);

   typedef struct packed {
      logic [sba_pkg::RESULT_W-1:0] value;
      logic                         div_zero;
   } alu_answer_type;

   alu_answer_type pending_answers[$];

   // expected response of one operation, wrapped to the result width
   function automatic alu_answer_type alu_outcome(
         input logic [sba_pkg::FUNC_W-1:0]           op,
         input logic signed [sba_pkg::OPERAND_W-1:0] a,
         input logic signed [sba_pkg::OPERAND_W-1:0] b);
      alu_answer_type ans;
      int             sa;
      int             sb;
      int             full;
      sa   = a;
      sb   = b;
      full = 0;
      ans  = '0;
      case (op)
         sba_pkg::FUNC_ADD: full = sa + sb;
         sba_pkg::FUNC_SUB: full = sa - sb;
         sba_pkg::FUNC_MUL: full = sa * sb;
         sba_pkg::FUNC_DIV: begin
            // most negative over minus one gives +128, which wraps back
            if (sb == 0) ans.div_zero = 1'b1;
            else full = sa / sb;
         end
         sba_pkg::FUNC_REM: begin
            if (sb == 0) ans.div_zero = 1'b1;
            else full = sa % sb;
         end
         default: full = 0;
      endcase
      ans.value = full[sba_pkg::RESULT_W-1:0];
      return ans;
   endfunction

   // queue expectations on req beats, compare on rsp beats
   always @(posedge clock) begin : scoreboard
      alu_answer_type want;
      int             errs;
      errs = 0;
      if (reset) begin
         pending_answers.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            pending_answers.push_back(alu_outcome(req_tuser,
                                      req_tdata[sba_pkg::OPERAND_W-1:0],
                                      req_tdata[2*sba_pkg::OPERAND_W-1:sba_pkg::OPERAND_W]));
         end
         if (rsp_tvalid && rsp_tready) begin
            if (pending_answers.size() == 0) begin
               $display("%0t: unexpected rsp beat: result %0d div_zero %0b",
                        $time, $signed(rsp_tdata), rsp_tuser[0]);
               errs = errs + 1;
            end else begin
               want = pending_answers.pop_front();
               checked_count <= checked_count + 1;
               if (rsp_tdata !== want.value) begin
                  $display("%0t: result mismatch: expected %0d, got %0d",
                           $time, $signed(want.value), $signed(rsp_tdata));
                  errs = errs + 1;
               end
               if (rsp_tuser[0] !== want.div_zero) begin
                  $display("%0t: divide_by_zero mismatch: expected %0b, got %0b",
                           $time, want.div_zero, rsp_tuser[0]);
                  errs = errs + 1;
               end
            end
         end
      end
      error_count <= error_count + errs;
      outstanding <= pending_answers.size();
   end

endmodule

// File: sim/signed_byte_alu_tb.sv
// ----------------------------------------------------------------------------
// signed_byte_alu_tb
// Drives the signed byte ALU with a directed set of corner operations and
// then random operations under random req gaps and rsp back-pressure; the
// checker module predicts and compares every response.
// ----------------------------------------------------------------------------
module signed_byte_alu_tb;

   localparam int RANDOM_OPS  = 600;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_WAIT  = 20;

   // codes the block does not implement
   localparam logic [sba_pkg::FUNC_W-1:0] FUNC_SPARE_FIRST = 3'd5;
   localparam logic [sba_pkg::FUNC_W-1:0] FUNC_SPARE_LAST  = 3'd7;

   logic                            clock      = 1'b0;
   logic                            reset      = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [2*sba_pkg::OPERAND_W-1:0] req_tdata  = '0;   // [7:0] operand_a, [15:8] operand_b
   logic [sba_pkg::FUNC_W-1:0]      req_tuser  = '0;   // [2:0] func
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [sba_pkg::RESULT_W-1:0]    rsp_tdata;         // [7:0] result
   logic [0:0]                      rsp_tuser;         // [0] divide_by_zero

   int error_count;
   int outstanding;
   int checked_count;
   int cycle_count  = 0;
   int sent_count   = 0;
   int zero_div_cnt = 0;
   int spare_cnt    = 0;
   int send_burst   = 0;
   int rsp_burst    = 0;
   int rsp_stall    = 0;

   always #10 clock = ~clock;

   signed_byte_alu #(
      .DATA_WIDTH (8)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   signed_byte_alu_checker monitor (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .error_count   (error_count),
      .outstanding   (outstanding),
      .checked_count (checked_count)
   );

   // gap length: mostly none or short, now and then long, with gap-free bursts
   function automatic int pick_gap(inout int burst_left);
      int r;
      if (burst_left > 0) begin
         burst_left = burst_left - 1;
         return 0;
      end
      if ($urandom_range(0, 39) == 0) begin
         burst_left = $urandom_range(10, 40);
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 50);
   endfunction

   // operand biased toward the interesting values
   function automatic logic [sba_pkg::OPERAND_W-1:0] pick_operand();
      if ($urandom_range(0, 99) < 20) begin
         case ($urandom_range(0, 4))
            0: return 8'h80;
            1: return 8'h7F;
            2: return 8'hFF;
            3: return 8'h00;
            default: return 8'h01;
         endcase
      end
      return 8'($urandom_range(0, 255));
   endfunction

   // rsp back-pressure, changed at the falling edge
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_stall  <= rsp_stall - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_stall  <= pick_gap(rsp_burst);
         rsp_tready <= 1'b1;
      end
   end

   // run timeout
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, outstanding);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // one req beat, called and returning at a falling edge
   task automatic send_op(input logic [sba_pkg::FUNC_W-1:0] op,
                          input logic [sba_pkg::OPERAND_W-1:0] a,
                          input logic [sba_pkg::OPERAND_W-1:0] b);
      int gap;
      gap = pick_gap(send_burst);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {b, a};
      do @(posedge clock); while (!req_tready);
      sent_count = sent_count + 1;
      if ((op == sba_pkg::FUNC_DIV || op == sba_pkg::FUNC_REM) && b == '0) begin
         zero_div_cnt = zero_div_cnt + 1;
      end
      if (op > sba_pkg::FUNC_REM) spare_cnt = spare_cnt + 1;
      @(negedge clock);
   endtask

   initial begin
      logic [sba_pkg::FUNC_W-1:0]    op;
      logic [sba_pkg::OPERAND_W-1:0] a;
      logic [sba_pkg::OPERAND_W-1:0] b;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed corners: wrap, most negative cases, zero divisor, spare codes
      send_op(sba_pkg::FUNC_ADD, 8'h7F, 8'h01);
      send_op(sba_pkg::FUNC_ADD, 8'h80, 8'hFF);
      send_op(sba_pkg::FUNC_ADD, 8'h00, 8'h00);
      send_op(sba_pkg::FUNC_SUB, 8'h80, 8'h01);
      send_op(sba_pkg::FUNC_SUB, 8'h7F, 8'h80);
      send_op(sba_pkg::FUNC_MUL, 8'h80, 8'hFF);
      send_op(sba_pkg::FUNC_MUL, 8'h7F, 8'h7F);
      send_op(sba_pkg::FUNC_MUL, 8'h05, 8'h80);
      send_op(sba_pkg::FUNC_MUL, 8'h80, 8'h80);
      send_op(sba_pkg::FUNC_DIV, 8'h80, 8'hFF);
      send_op(sba_pkg::FUNC_DIV, 8'h07, 8'hFE);
      send_op(sba_pkg::FUNC_DIV, 8'hF9, 8'h02);
      send_op(sba_pkg::FUNC_DIV, 8'h64, 8'h00);
      send_op(sba_pkg::FUNC_DIV, 8'h00, 8'h00);
      send_op(sba_pkg::FUNC_REM, 8'h80, 8'hFF);
      send_op(sba_pkg::FUNC_REM, 8'hF9, 8'h02);
      send_op(sba_pkg::FUNC_REM, 8'h07, 8'hFE);
      send_op(sba_pkg::FUNC_REM, 8'hFB, 8'h00);
      send_op(sba_pkg::FUNC_REM, 8'h80, 8'h7F);
      for (int f = FUNC_SPARE_FIRST; f <= FUNC_SPARE_LAST; f++) begin
         send_op(f[sba_pkg::FUNC_W-1:0], 8'h80, 8'h7F);
      end

      // random operations, mostly implemented codes
      repeat (RANDOM_OPS) begin
         if ($urandom_range(0, 99) < 94) begin
            op = 3'($urandom_range(sba_pkg::FUNC_ADD, sba_pkg::FUNC_REM));
         end else begin
            op = 3'($urandom_range(FUNC_SPARE_FIRST, FUNC_SPARE_LAST));
         end
         a = pick_operand();
         b = ($urandom_range(0, 99) < 8) ? '0 : pick_operand();
         send_op(op, a, b);
      end
      req_tvalid <= 1'b0;

      // drain outstanding responses, then let any late beat show up
      while (outstanding != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);

      $display("sent %0d operations (%0d zero divisors, %0d unused codes)",
               sent_count, zero_div_cnt, spare_cnt);
      $display("checked %0d responses, %0d errors", checked_count, error_count);
      if (error_count == 0 && outstanding == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// File: signed_byte_alu.f
+incdir+rtl
rtl/sba_pkg.sv
rtl/sba_addsub.sv
rtl/sba_muldiv.sv
rtl/signed_byte_alu.sv
sim/signed_byte_alu_checker.sv
sim/signed_byte_alu_tb.sv
